// ----- rtl/cpi_pkg.sv -----
// shared types and constants of the color palette indexer
package cpi_pkg;

  localparam int COLOR_W          = 8;
  localparam int KEY_W            = 3 * COLOR_W;
  localparam int LABEL_W          = 9;
  localparam int PALETTE_SIZE_DEF = 256;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
  } pixel_t;

  typedef struct packed {
    logic               done;
    logic [LABEL_W-1:0] color_label;
    logic               new_color;
    logic               palette_full;
    logic [LABEL_W-1:0] color_count;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_CMP,
    BK_RESOLVE
  } back_state_t;

endpackage

// ----- rtl/color_palette_indexer_unit.sv -----
// top level of the color palette indexer
// Each pixel transfer (start high while busy is low) is packed into a 24-bit key and
// queued in a two-entry queue; busy is high only while that queue is full. A search
// engine takes one pixel at a time and compares its key with the stored palette
// entries in order, each entry read in a read state and then checked in a compare
// state, through the single registered read port of the palette memory. A pixel
// whose color sits in slot k (zero based) is compared with slots 0 to k; a new color
// is compared with all n colors stored so far, and with an empty palette the engine
// goes straight from idle to resolve. The result is on the output ports for exactly
// one cycle with done high, one cycle after the engine finishes, and must be taken
// then: it is never held. Labels and counts are one based and wrap to 9 bits. After
// a pixel marked last_of_image the palette is empty again; no clearing pass is
// needed since only entries below the color count are ever read.
module color_palette_indexer_unit #(
  parameter int PALETTE_SIZE = cpi_pkg::PALETTE_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic       last_of_image,
  output logic       done,
  output logic [8:0] color_label,
  output logic       new_color,
  output logic       palette_full,
  output logic [8:0] color_count
);
  import cpi_pkg::*;

  // queue head handed from the front part to the search engine
  pixel_t  head;
  logic    empty;
  logic    pop;
  result_t res;

  // front: key packing and pixel queue
  cpi_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .last_of_image (last_of_image),
    .busy          (busy),
    .pop           (pop),
    .empty         (empty),
    .head          (head)
  );

  // back: palette memory, search sequencer and result register
  cpi_back #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (empty),
    .head  (head),
    .pop   (pop),
    .res   (res)
  );

  assign done         = res.done;
  assign color_label  = res.color_label;
  assign new_color    = res.new_color;
  assign palette_full = res.palette_full;
  assign color_count  = res.color_count;

`ifndef SYNTH
  // a result is either an insertion or an overflow, never both
  a_new_or_full : assert property (@(posedge clk) disable iff (rst)
    done |-> !(new_color && palette_full))
    else $error("new_color and palette_full both set");

  // overflow gives label zero
  a_full_label : assert property (@(posedge clk) disable iff (rst)
    (done && palette_full) |-> (color_label == '0))
    else $error("overflow result with nonzero label");

  // a new color takes the label equal to the updated count
  a_new_label : assert property (@(posedge clk) disable iff (rst)
    (done && new_color) |-> (color_label == color_count))
    else $error("new color label differs from color count");

  // a known color has a label within the stored count
  a_hit_label : assert property (@(posedge clk) disable iff (rst)
    (done && !new_color && !palette_full && PALETTE_SIZE < 512)
      |-> (color_label != '0 && color_label <= color_count))
    else $error("known color label out of range");
`endif

endmodule

// ----- rtl/cpi_front.sv -----
// front part: packs pixels into keys and queues them for the search engine
module cpi_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [7:0]      red,
  input  logic [7:0]      green,
  input  logic [7:0]      blue,
  input  logic            last_of_image,
  output logic            busy,
  input  logic            pop,
  output logic            empty,
  output cpi_pkg::pixel_t head
);
  import cpi_pkg::*;

  pixel_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              push;
  logic              take;

  assign busy  = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign push  = start && !busy;
  assign take  = pop && !empty;
  assign head  = slots[rd_ptr];

  // red in the low byte, blue in the high byte
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].key  <= {blue, green, red};
      slots[wr_ptr].last <= last_of_image;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (take) rd_ptr <= rd_ptr + 1'b1;
      if (push && !take) fill <= fill + 1'b1;
      else if (take && !push) fill <= fill - 1'b1;
    end
  end

endmodule

// ----- rtl/cpi_back.sv -----
// back part: linear palette search, insertion of new colors and result register
module cpi_back #(
  parameter int PALETTE_SIZE = cpi_pkg::PALETTE_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  cpi_pkg::pixel_t  head,
  output logic             pop,
  output cpi_pkg::result_t res
);
  import cpi_pkg::*;

  localparam int CNT_W = $clog2(PALETTE_SIZE + 1);
  localparam int IDX_W = $clog2(PALETTE_SIZE);

  logic [KEY_W-1:0] keys [PALETTE_SIZE];
  logic [KEY_W-1:0] rd_data;

  back_state_t      state;
  back_state_t      state_next;
  pixel_t           cur;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] match_idx;
  logic             found;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             hit;
  logic             last_entry;
  logic             room;
  logic             wr_en;
  logic             rd_en;

  assign hit        = (rd_data == cur.key);
  assign last_entry = ((CNT_W'(idx) + 1'b1) == count);
  assign room       = (count != CNT_W'(PALETTE_SIZE));
  assign count_next = count + 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!empty) state_next = (count == '0) ? BK_RESOLVE : BK_READ;
      end
      BK_READ:    state_next = BK_CMP;
      BK_CMP: begin
        if (hit || last_entry) state_next = BK_RESOLVE;
        else state_next = BK_READ;
      end
      BK_RESOLVE: state_next = BK_IDLE;
      default:    state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop   = 1'b0;
    rd_en = 1'b0;
    wr_en = 1'b0;
    case (state)
      BK_IDLE:    pop   = !empty;
      BK_READ:    rd_en = 1'b1;
      BK_CMP:     ;
      BK_RESOLVE: wr_en = !found && room;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= keys[idx];
    if (wr_en) keys[count[IDX_W-1:0]] <= cur.key;
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      count    <= '0;
      res.done <= 1'b0;
    end else begin
      state    <= state_next;
      res.done <= (state == BK_RESOLVE);
      if (state == BK_RESOLVE) begin
        if (cur.last) count <= '0;
        else if (wr_en) count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        idx   <= '0;
        found <= 1'b0;
      end
      BK_CMP: begin
        if (hit) begin
          found     <= 1'b1;
          match_idx <= idx;
        end
        idx <= idx + 1'b1;
      end
      BK_RESOLVE: begin
        if (found) begin
          res.color_label  <= LABEL_W'(CNT_W'(match_idx) + 1'b1);
          res.new_color    <= 1'b0;
          res.palette_full <= 1'b0;
          res.color_count  <= LABEL_W'(count);
        end else if (room) begin
          res.color_label  <= LABEL_W'(count_next);
          res.new_color    <= 1'b1;
          res.palette_full <= 1'b0;
          res.color_count  <= LABEL_W'(count_next);
        end else begin
          res.color_label  <= '0;
          res.new_color    <= 1'b0;
          res.palette_full <= 1'b1;
          res.color_count  <= LABEL_W'(count);
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- test/color_palette_indexer_unit_test.sv -----
// self-checking testbench of the color palette indexer top level
module color_palette_indexer_unit_test;

  // the block is built with its default palette depth
  localparam int PALETTE_SIZE = cpi_pkg::PALETTE_SIZE_DEF;
  localparam logic [15:0] LAST_SLOT = 16'(PALETTE_SIZE - 1);
  // fill colors all share this blue value, so they collide with no rows but the fill lookups
  localparam logic [7:0] FILL_BLUE = 8'h99;

  // one result as the block reports it
  typedef struct packed {
    logic [8:0] label;
    logic       fresh;
    logic       full;
    logic [8:0] count;
  } label_result_t;

  typedef enum {ROW_PREDICT, ROW_TYPED, ROW_FILL} row_kind_t;

  // one line of the directed table
  typedef struct {
    row_kind_t     kind;
    logic [7:0]    r;
    logic [7:0]    g;
    logic [7:0]    b;
    logic          last;
    label_result_t want;
  } pixel_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] red = '0;
  logic [7:0] green = '0;
  logic [7:0] blue = '0;
  logic       last_of_image = 1'b0;
  logic       done;
  logic [8:0] color_label;
  logic       new_color;
  logic       palette_full;
  logic [8:0] color_count;

  // side information that travels with the pixel on the input side
  logic          tag_typed = 1'b0;
  label_result_t tag_want = '0;

  // own copy of the palette contents and the number of stored colors
  logic [23:0] known_keys [PALETTE_SIZE];
  int unsigned known_count = 0;

  label_result_t pending_labels [$];
  label_result_t seen_result;
  label_result_t due_result;
  pixel_row_t    directed_rows [$];
  int            mismatch_count = 0;
  int            pixels_sent = 0;

  color_palette_indexer_unit #(.PALETTE_SIZE(PALETTE_SIZE)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .red(red),
    .green(green),
    .blue(blue),
    .last_of_image(last_of_image),
    .done(done),
    .color_label(color_label),
    .new_color(new_color),
    .palette_full(palette_full),
    .color_count(color_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // label lookup with palette update; the count is taken before the end-of-image clear
  function automatic label_result_t lookup_color(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b, input logic last);
    logic [23:0]   key;
    label_result_t res;
    bit            hit;
    key = {b, g, r};
    res = '0;
    hit = 1'b0;
    for (int i = 0; i < known_count; i++) begin
      if (!hit && known_keys[i] == key) begin
        res.label = 9'(i + 1);
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (known_count < PALETTE_SIZE) begin
        // unseen color goes to the next free slot
        known_keys[known_count] = key;
        known_count++;
        res.label = 9'(known_count);
        res.fresh = 1'b1;
      end else begin
        // palette overflow: label 0, nothing stored
        res.full = 1'b1;
      end
    end
    res.count = 9'(known_count);
    if (last) known_count = 0;
    return res;
  endfunction

  function automatic pixel_row_t typed_row(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b, input logic last,
                                           input label_result_t want);
    pixel_row_t row;
    row.kind = ROW_TYPED;
    row.r = r;
    row.g = g;
    row.b = b;
    row.last = last;
    row.want = want;
    return row;
  endfunction

  function automatic pixel_row_t plain_row(input row_kind_t kind, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] b,
                                           input logic last);
    pixel_row_t row;
    row.kind = kind;
    row.r = r;
    row.g = g;
    row.b = b;
    row.last = last;
    row.want = '0;
    return row;
  endfunction

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: label %0d/%0d new %0b/%0b full %0b/%0b count %0d/%0d (got/expected)",
               what, seen_result.label, due_result.label, seen_result.fresh, due_result.fresh,
               seen_result.full, due_result.full, seen_result.count, due_result.count);
  endfunction

  // result check and input tracking, both on values sampled at the clock edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        seen_result = '{color_label, new_color, palette_full, color_count};
        if (pending_labels.size() == 0) begin
          due_result = '0;
          note_mismatch("result with no pixel pending");
        end else begin
          due_result = pending_labels.pop_front();
          if (seen_result.label !== due_result.label || seen_result.fresh !== due_result.fresh
              || seen_result.full !== due_result.full
              || seen_result.count !== due_result.count)
            note_mismatch("result mismatch");
        end
      end
      // a pixel transfer: start high while busy is low
      if (start && !busy) begin
        due_result = lookup_color(red, green, blue, last_of_image);
        // rows with a typed expectation still update the palette copy above
        if (tag_typed) due_result = tag_want;
        pending_labels.push_back(due_result);
      end
    end
  end

  // present one pixel and hold it until the block takes it
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic last, input logic typed, input label_result_t want);
    start <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    last_of_image <= last;
    tag_typed <= typed;
    tag_want <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
    pixels_sent++;
  endtask

  // random sender gap, taken with a chance of pct percent
  task automatic idle_gap(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // sender holds off until every pending result has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_labels.size() != 0) @(posedge clk);
  endtask

  // images made mostly of a small working set of colors, so labels repeat
  task automatic random_images(input int n_items, input int idle_pct);
    int          goal;
    int          len;
    int          set_size;
    bit          big;
    logic [23:0] working_set [$];
    logic [23:0] c;
    logic        last;
    int          pick;
    goal = pixels_sent + n_items;
    while (pixels_sent < goal) begin
      // now and then a large image of random colors that can run the palette over
      big = ($urandom_range(0, 39) == 0);
      len = big ? $urandom_range(200, 300) : $urandom_range(1, 40);
      set_size = $urandom_range(1, 12);
      working_set.delete();
      for (int k = 0; k < set_size; k++) working_set.push_back(24'($urandom()));
      for (int p = 0; p < len && pixels_sent < goal; p++) begin
        pick = $urandom_range(0, 99);
        if (big || (pick >= 85 && pick < 95)) begin
          c = 24'($urandom());
        end else if (pick >= 95) begin
          // extreme components: each 00 or ff
          c = {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
               {8{$urandom_range(0, 1) == 1}}};
        end else begin
          c = working_set[$urandom_range(0, set_size - 1)];
        end
        // an image mostly ends with last_of_image; sometimes it is missing or early
        if (p == len - 1) last = ($urandom_range(0, 9) != 0);
        else last = ($urandom_range(0, 49) == 0);
        idle_gap(idle_pct);
        send_pixel(c[7:0], c[15:8], c[23:16], last, 1'b0, '0);
      end
    end
  endtask

  initial begin
    // directed table: known labels after reset, repeats, end of image, overflow
    directed_rows.push_back(typed_row(8'h00, 8'h00, 8'h00, 1'b0, '{9'd1, 1'b1, 1'b0, 9'd1}));
    directed_rows.push_back(typed_row(8'hff, 8'hff, 8'hff, 1'b0, '{9'd2, 1'b1, 1'b0, 9'd2}));
    directed_rows.push_back(typed_row(8'h00, 8'h00, 8'h00, 1'b0, '{9'd1, 1'b0, 1'b0, 9'd2}));
    directed_rows.push_back(typed_row(8'hff, 8'h00, 8'h00, 1'b0, '{9'd3, 1'b1, 1'b0, 9'd3}));
    directed_rows.push_back(typed_row(8'h00, 8'hff, 8'h00, 1'b0, '{9'd4, 1'b1, 1'b0, 9'd4}));
    directed_rows.push_back(typed_row(8'h00, 8'h00, 8'hff, 1'b0, '{9'd5, 1'b1, 1'b0, 9'd5}));
    directed_rows.push_back(typed_row(8'hff, 8'hff, 8'hff, 1'b0, '{9'd2, 1'b0, 1'b0, 9'd5}));
    // end of image: count reported before the clear
    directed_rows.push_back(typed_row(8'h00, 8'h00, 8'hff, 1'b1, '{9'd5, 1'b0, 1'b0, 9'd5}));
    directed_rows.push_back(typed_row(8'h00, 8'h00, 8'hff, 1'b0, '{9'd1, 1'b1, 1'b0, 9'd1}));
    // bit patterns, two of which hold the same bytes in swapped channels
    directed_rows.push_back(plain_row(ROW_PREDICT, 8'h01, 8'h02, 8'h04, 1'b0));
    directed_rows.push_back(plain_row(ROW_PREDICT, 8'h04, 8'h02, 8'h01, 1'b0));
    directed_rows.push_back(plain_row(ROW_PREDICT, 8'h80, 8'h40, 8'h20, 1'b0));
    directed_rows.push_back(plain_row(ROW_PREDICT, 8'hff, 8'h00, 8'hff, 1'b0));
    directed_rows.push_back(plain_row(ROW_PREDICT, 8'h01, 8'h02, 8'h04, 1'b0));
    directed_rows.push_back(plain_row(ROW_PREDICT, 8'haa, 8'h55, 8'haa, 1'b1));
    // single-pixel image
    directed_rows.push_back(typed_row(8'h55, 8'haa, 8'h55, 1'b1, '{9'd1, 1'b1, 1'b0, 9'd1}));
    // fill every slot with distinct colors, then overflow
    directed_rows.push_back(plain_row(ROW_FILL, 8'h00, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(typed_row(8'h00, 8'h00, 8'h00, 1'b0,
                                      '{9'd0, 1'b0, 1'b1, 9'(PALETTE_SIZE)}));
    directed_rows.push_back(typed_row(8'h00, 8'h00, FILL_BLUE, 1'b0,
                                      '{9'd1, 1'b0, 1'b0, 9'(PALETTE_SIZE)}));
    directed_rows.push_back(typed_row(LAST_SLOT[7:0], LAST_SLOT[15:8], FILL_BLUE, 1'b0,
                                      '{9'(PALETTE_SIZE), 1'b0, 1'b0, 9'(PALETTE_SIZE)}));
    // overflow on the last pixel still clears the palette
    directed_rows.push_back(typed_row(8'h12, 8'h34, 8'h56, 1'b1,
                                      '{9'd0, 1'b0, 1'b1, 9'(PALETTE_SIZE)}));
    directed_rows.push_back(typed_row(8'h12, 8'h34, 8'h56, 1'b0, '{9'd1, 1'b1, 1'b0, 9'd1}));
    directed_rows.push_back(typed_row(8'h12, 8'h34, 8'h56, 1'b1, '{9'd1, 1'b0, 1'b0, 9'd1}));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[n]) begin
      if (directed_rows[n].kind == ROW_FILL) begin
        for (int i = 0; i < PALETTE_SIZE; i++) begin
          idle_gap(32);
          send_pixel(8'(i), 8'(i >> 8), FILL_BLUE, 1'b0, 1'b0, '0);
        end
        // let the full palette settle before the overflow rows
        wait_drained();
      end else begin
        idle_gap(32);
        send_pixel(directed_rows[n].r, directed_rows[n].g, directed_rows[n].b,
                   directed_rows[n].last, directed_rows[n].kind == ROW_TYPED,
                   directed_rows[n].want);
      end
    end
    wait_drained();

    // random images: light sender gaps, heavy gaps, then back to back
    random_images(280, 32);
    wait_drained();
    random_images(280, 72);
    wait_drained();
    random_images(265, 0);

    // all transfers made: wait for the tail, then a quiet wait for strays
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_labels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog well above the slowest legal run
  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cpi_pkg.sv
rtl/cpi_front.sv
rtl/cpi_back.sv
rtl/color_palette_indexer_unit.sv
test/color_palette_indexer_unit_test.sv
